// ===== rtl/uta_pkg.sv =====
`timescale 1ns / 1ps

package uta_pkg;

    localparam int VALUE_BITS = 64;
    localparam int NCELLS     = (VALUE_BITS + 2) / 3;
    localparam int BIT_W      = $clog2(VALUE_BITS);
    localparam int NDIG_W     = $clog2(NCELLS + 1);

    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [3:0] DEC_BASE     = 4'd10;

    typedef struct packed {
        logic [63:0] number;
        logic [1:0]  radix_select;
        logic [5:0]  min_width;
        logic [7:0]  pad_char;
        logic        upper_hex;
    } t_in;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_CLEAR  = 2'd1,
        CELL_DOUBLE = 2'd2,
        CELL_SHIFT  = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op   op;
        logic [1:0] radix;
    } t_cell_ctrl;

    function automatic logic [7:0] uta_digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        if (d < DEC_BASE) begin
            return CHAR_ZERO + {4'b0, d};
        end
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        return base + {4'b0, d} - {4'b0, DEC_BASE};
    endfunction

endpackage

// ===== rtl/uta_cell.sv =====
`timescale 1ns / 1ps

module uta_cell (
    input  logic              i_clk,
    input  uta_pkg::t_cell_ctrl i_ctrl,
    input  logic              i_carry,
    input  logic [3:0]        i_digit,
    output logic              o_carry,
    output logic [3:0]        o_digit
);
    import uta_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [4:0] w_sum;
    logic [3:0] w_dbl;

    assign w_sum   = {r_digit, i_carry};
    assign o_digit = r_digit;

    // digit times two plus incoming bit, reduced by the radix
    always_comb begin
        unique case (i_ctrl.radix)
            RADIX_HEX: begin
                w_dbl   = w_sum[3:0];
                o_carry = w_sum[4];
            end
            RADIX_OCT: begin
                w_dbl   = {1'b0, w_sum[2:0]};
                o_carry = w_sum[3];
            end
            default: begin
                if (w_sum >= {1'b0, DEC_BASE}) begin
                    w_dbl   = 4'(w_sum - {1'b0, DEC_BASE});
                    o_carry = 1'b1;
                end else begin
                    w_dbl   = w_sum[3:0];
                    o_carry = 1'b0;
                end
            end
        endcase
    end

    always_comb begin
        unique case (i_ctrl.op)
            CELL_CLEAR:  n_digit = '0;
            CELL_DOUBLE: n_digit = w_dbl;
            CELL_SHIFT:  n_digit = i_digit;
            default:     n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ===== rtl/unsigned_to_ascii_formatter.sv =====
// the value is shifted in as binary through the digit cell chain, then leading zeros
// are dropped, then the characters go out (pads, then digits), one per cycle within
// each run while the output is not stalled; a new request is taken only back in
// idle, after the last digit of the previous one has been loaded for output
// reset: synchronous, active low; clears the control state machine and output valid
`timescale 1ns / 1ps

module unsigned_to_ascii_formatter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  uta_pkg::t_in  i_data,
    output logic         o_valid,
    input  logic         i_stall,
    output uta_pkg::t_out o_data
);
    import uta_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_SKIP  = 5'b00100,
        ST_PAD   = 5'b01000,
        ST_DIGIT = 5'b10000
    } t_state;

    t_state                  r_state, n_state;
    logic [VALUE_BITS-1:0]   r_value, n_value;
    logic [BIT_W-1:0]        r_bit, n_bit;
    logic [NDIG_W-1:0]       r_ndig, n_ndig;
    logic [5:0]              r_pads, n_pads;
    logic [5:0]              r_width;
    logic [7:0]              r_pad_char;
    logic                    r_upper;
    logic [1:0]              r_radix;
    logic                    r_out_valid, n_out_valid;
    t_out                    r_out, n_out;

    t_cell_ctrl              w_ctrl;
    logic                    w_accept;
    logic                    w_free;
    logic                    w_load;
    logic [3:0]              w_top;
    logic [NCELLS:0]         w_carry;
    logic [3:0]              w_digit [NCELLS];

    assign w_accept = i_valid && !o_stall;
    assign o_stall  = (r_state != ST_IDLE);
    assign w_free   = !r_out_valid || !i_stall;
    assign w_top    = w_digit[NCELLS-1];
    assign w_carry[0] = r_value[VALUE_BITS-1];
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    genvar gi;
    generate
        for (gi = 0; gi < NCELLS; gi++) begin : g_cell
            logic [3:0] w_lower;
            if (gi == 0) begin : g_first
                assign w_lower = '0;
            end else begin : g_rest
                assign w_lower = w_digit[gi-1];
            end
            uta_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl),
                .i_carry (w_carry[gi]),
                .i_digit (w_lower),
                .o_carry (w_carry[gi+1]),
                .o_digit (w_digit[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_bit       = r_bit;
        n_ndig      = r_ndig;
        n_pads      = r_pads;
        n_out       = r_out;
        w_load      = 1'b0;
        w_ctrl.op   = CELL_HOLD;
        w_ctrl.radix = r_radix;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    w_ctrl.op = CELL_CLEAR;
                    n_value   = i_data.number[VALUE_BITS-1:0];
                    n_bit     = BIT_W'(VALUE_BITS - 1);
                    n_state   = ST_CONV;
                end
            end
            ST_CONV: begin
                w_ctrl.op = CELL_DOUBLE;
                n_value   = {r_value[VALUE_BITS-2:0], 1'b0};
                n_bit     = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_ndig  = NDIG_W'(NCELLS);
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if (w_top == '0 && r_ndig > NDIG_W'(1)) begin
                    w_ctrl.op = CELL_SHIFT;
                    n_ndig    = r_ndig - 1'b1;
                end else begin
                    n_pads  = (r_width > 6'(r_ndig)) ? r_width - 6'(r_ndig) : '0;
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                if (r_pads == '0) begin
                    n_state = ST_DIGIT;
                end else if (w_free) begin
                    w_load          = 1'b1;
                    n_out.out_char  = r_pad_char;
                    n_out.last_char = 1'b0;
                    n_pads          = r_pads - 1'b1;
                end
            end
            ST_DIGIT: begin
                if (w_free) begin
                    w_load          = 1'b1;
                    w_ctrl.op       = CELL_SHIFT;
                    n_out.out_char  = uta_digit_char(w_top, r_upper);
                    n_out.last_char = (r_ndig == NDIG_W'(1));
                    n_ndig          = r_ndig - 1'b1;
                    if (r_ndig == NDIG_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        n_out_valid = w_load ? 1'b1 : (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_bit   <= n_bit;
        r_ndig  <= n_ndig;
        r_pads  <= n_pads;
        r_out   <= n_out;
        if (w_accept) begin
            r_width    <= i_data.min_width;
            r_pad_char <= i_data.pad_char;
            r_upper    <= i_data.upper_hex;
            r_radix    <= i_data.radix_select;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV) |-> !w_carry[NCELLS])
        else $error("digit chain overflow");

    a_ndig_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIGIT || r_state == ST_PAD) |-> (r_ndig != '0))
        else $error("digit count empty while emitting");

    a_accept_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_CONV))
        else $error("request not taken into conversion");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_out.last_char) |=> (r_state == ST_IDLE && r_out_valid))
        else $error("last character without return to idle");
`endif

endmodule

// ===== dv/unsigned_to_ascii_formatter_tb.sv =====
`timescale 1ns / 1ps

module unsigned_to_ascii_formatter_tb;
    import uta_pkg::*;

    class uta_char_scoreboard;
        t_out        expected_chars[$];
        int unsigned mismatches;
        int unsigned chars_seen;
        int unsigned numbers_seen;

        function new();
            mismatches   = 0;
            chars_seen   = 0;
            numbers_seen = 0;
        endfunction

        // expand one request into the characters it should print
        function void note_request(t_in req);
            logic [63:0] value;
            logic [63:0] rem;
            logic [3:0]  d;
            logic [7:0]  lsd_first[$];
            logic [7:0]  letter_base;
            int unsigned total;
            int unsigned ndig;
            t_out        ch;
            value       = req.number & ({64{1'b1}} >> (64 - VALUE_BITS));
            letter_base = req.upper_hex ? CHAR_UPPER_A : CHAR_LOWER_A;
            do begin
                case (req.radix_select)
                    RADIX_HEX: begin
                        d     = value[3:0];
                        value = value >> 4;
                    end
                    RADIX_OCT: begin
                        d     = {1'b0, value[2:0]};
                        value = value >> 3;
                    end
                    default: begin
                        rem   = value % 64'd10;
                        d     = rem[3:0];
                        value = value / 64'd10;
                    end
                endcase
                if (d < DEC_BASE) begin
                    lsd_first.push_back(CHAR_ZERO + {4'b0, d});
                end else begin
                    lsd_first.push_back(letter_base + {4'b0, d} - {4'b0, DEC_BASE});
                end
            end while (value != 64'd0);
            ndig  = lsd_first.size();
            total = (req.min_width > ndig) ? req.min_width : ndig;
            for (int unsigned k = 0; k < total; k++) begin
                if (k < total - ndig) begin
                    ch.out_char = req.pad_char;
                end else begin
                    ch.out_char = lsd_first[total - 1 - k];
                end
                ch.last_char = (k + 1 == total);
                expected_chars.push_back(ch);
            end
            numbers_seen++;
        endfunction

        function void check_char(t_out got);
            t_out want;
            chars_seen++;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("error: char 0x%02h last=%0b arrived with nothing pending",
                             got.out_char, got.last_char);
                end
                return;
            end
            want = expected_chars.pop_front();
            if (got.out_char !== want.out_char || got.last_char !== want.last_char) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("error: char expected 0x%02h last=%0b, got 0x%02h last=%0b",
                             want.out_char, want.last_char, got.out_char, got.last_char);
                end
            end
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    t_in  i_data  = '0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    t_out o_data;

    uta_char_scoreboard chars;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    unsigned_to_ascii_formatter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // output side: check accepted characters, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            chars.check_char(o_data);
        end
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic t_in make_request(logic [63:0] number, logic [1:0] radix,
                                         logic [5:0] width, logic [7:0] pad, logic upper);
        t_in req;
        req.number       = number;
        req.radix_select = radix;
        req.min_width    = width;
        req.pad_char     = pad;
        req.upper_hex    = upper;
        return req;
    endfunction

    function automatic t_in random_request();
        t_in         req;
        int unsigned nbits;
        req.number = {$urandom, $urandom};
        case ($urandom_range(9))
            0, 1, 2, 3: ;
            4, 5, 6, 7: begin
                nbits = $urandom_range(63, 1);
                req.number = req.number & ((64'd1 << nbits) - 64'd1);
            end
            8: req.number = 64'($urandom_range(20));
            default: req.number = {64{1'b1}} >> $urandom_range(63);
        endcase
        req.radix_select = 2'($urandom_range(3));
        if ($urandom_range(7) == 0) begin
            req.min_width = 6'($urandom_range(63));
        end else begin
            req.min_width = 6'($urandom_range(24));
        end
        req.pad_char  = 8'($urandom_range(255));
        req.upper_hex = 1'($urandom_range(1));
        return req;
    endfunction

    task automatic send_request(t_in req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        chars.note_request(req);
    endtask

    // hold the input side quiet until every pending character is out
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (chars.expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        t_in directed[$];
        chars = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(make_request(64'd0, RADIX_DEC, 6'd0, 8'h20, 1'b0));
        directed.push_back(make_request(64'd0, RADIX_HEX, 6'd63, 8'h2a, 1'b1));
        directed.push_back(make_request(64'd0, RADIX_OCT, 6'd1, 8'h00, 1'b0));
        directed.push_back(make_request({64{1'b1}}, RADIX_DEC, 6'd0, 8'h20, 1'b0));
        directed.push_back(make_request({64{1'b1}}, RADIX_HEX, 6'd0, 8'h20, 1'b1));
        directed.push_back(make_request({64{1'b1}}, RADIX_HEX, 6'd17, 8'h30, 1'b0));
        directed.push_back(make_request({64{1'b1}}, RADIX_OCT, 6'd63, 8'hff, 1'b0));
        directed.push_back(make_request(64'h0123_4567_89ab_cdef, RADIX_HEX, 6'd20, 8'h30, 1'b0));
        directed.push_back(make_request(64'hfedc_ba98_7654_3210, RADIX_HEX, 6'd16, 8'h2e, 1'b1));
        directed.push_back(make_request(64'd123, RADIX_DEC, 6'd2, 8'h20, 1'b0));
        directed.push_back(make_request(64'd7, RADIX_DEC, 6'd5, 8'h37, 1'b0));
        directed.push_back(make_request(64'hab, RADIX_HEX, 6'd6, 8'h61, 1'b0));
        directed.push_back(make_request(64'd255, 2'd3, 6'd4, 8'h5f, 1'b1));
        directed.push_back(make_request(64'd255, RADIX_OCT, 6'd0, 8'h20, 1'b1));
        directed.push_back(make_request(64'd10, RADIX_DEC, 6'd3, 8'h20, 1'b1));
        directed.push_back(make_request(64'd1, RADIX_HEX, 6'd63, 8'hff, 1'b0));
        directed.push_back(make_request(64'h8000_0000_0000_0000, RADIX_OCT, 6'd1, 8'h00, 1'b0));
        directed.push_back(make_request(64'h8000_0000_0000_0000, RADIX_DEC, 6'd25, 8'h2d, 1'b0));
        directed.push_back(make_request(64'd9999999999, RADIX_DEC, 6'd11, 8'h20, 1'b0));
        directed.push_back(make_request(64'd10000000000, RADIX_DEC, 6'd10, 8'h20, 1'b0));
        directed.push_back(make_request(64'h3fff_ffff, RADIX_DEC, 6'd0, 8'h20, 1'b0));
        directed.push_back(make_request(64'h4000_0000, RADIX_HEX, 6'd9, 8'h80, 1'b1));
        directed.push_back(make_request(64'hffff_ffff_ffff_fff0, 2'd3, 6'd21, 8'h7f, 1'b0));

        send_idle_pct  = 28;
        recv_stall_pct = 66;
        foreach (directed[n]) begin
            send_request(directed[n]);
        end
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 28;
                    recv_stall_pct = 66;
                end
                1: begin
                    send_idle_pct  = 66;
                    recv_stall_pct = 28;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (133) begin
                send_request(random_request());
            end
            wait_drained();
        end

        // anything arriving now has no request behind it
        repeat (100) @(posedge i_clk);

        $display("formatted %0d numbers into %0d characters over decimal, hex and octal,",
                 chars.numbers_seen, chars.chars_seen);
        $display("with padding widths 0..63 and both sides stalling; %0d mismatches",
                 chars.mismatches);
        if (chars.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
